/* sv/dsp_pkg.sv */
// Shared types, constants and codes for the shortest path engine.
`timescale 1ns / 1ps
package dsp_pkg;

	localparam int DEF_VERTICES = 16;
	localparam int DEF_WEIGHT_BITS = 16;
	localparam int VTX_W = 4;
	localparam int WEIGHT_FIELD_W = 16;
	localparam int DIST_W = 32;

	localparam logic [DIST_W-1:0] DIST_INF = 32'hFFFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_CAP = 32'hFFFF_FFFE;

	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_RUN = 1'b1;

	typedef struct packed {
		logic mode;
		logic [VTX_W-1:0] from_vertex;
		logic [VTX_W-1:0] to_vertex;
		logic [WEIGHT_FIELD_W-1:0] edge_weight;
	} dsp_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] target_distance;
		logic reachable;
		logic [VTX_W-1:0] target_echo;
	} dsp_rsp_t;

	typedef struct packed {
		logic valid;
		logic visited;
		logic clr_best;
	} dsp_relax_ctl_t;

endpackage

/* sv/dijkstra_shortest_path.sv */
// Top level of the dense-matrix shortest path engine.
// An edge beat with both vertices in range is written as it is accepted. In a run beat
// each round sweeps all vertices through the shared relaxation unit, one vertex a cycle,
// then drains its two-stage pipeline.
// After reset a clearing pass writes every adjacency entry, with req_stall held high.
`timescale 1ns / 1ps
module dijkstra_shortest_path #(
	parameter int VERTICES = dsp_pkg::DEF_VERTICES,
	parameter int WEIGHT_BITS = dsp_pkg::DEF_WEIGHT_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input dsp_pkg::dsp_req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output dsp_pkg::dsp_rsp_t rsp
);
	import dsp_pkg::*;

	localparam int VW = $clog2(VERTICES);
	localparam int AW = 2 * VW;
	localparam int VDEPTH = 1 << VW;
	localparam logic [VW-1:0] LAST_V = VW'(VERTICES - 1);
	localparam logic [VW-1:0] LAST_ROUND = VW'(VERTICES - 2);
	localparam logic [AW-1:0] LAST_ADDR = '1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_ROUND,
		S_FETCH,
		S_RESULT
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_addr_q;
	logic drain_q;
	logic [VW-1:0] u_q;
	logic [DIST_W-1:0] du_q;
	logic [VW-1:0] round_q;
	logic [VW-1:0] v_q;
	logic [VDEPTH-1:0] visited_q;
	logic [VTX_W-1:0] tgt_q;
	logic [VW-1:0] tgt_idx_q;
	logic tgt_ok_q;
	logic issue_s1;
	logic vis_s1;
	logic [VW-1:0] v_s1;
	dsp_rsp_t out_q;
	logic out_vld_q;

	logic [DIST_W-1:0] from_ext;
	logic [DIST_W-1:0] to_ext;
	logic [DIST_W-1:0] wb_ext;
	logic from_ok;
	logic to_ok;
	logic req_acc;
	logic edge_we;
	logic run_go;
	logic [VW-1:0] start_idx;
	logic [DIST_W-1:0] final_d;

	logic adj_we;
	logic [AW-1:0] adj_waddr;
	logic [WEIGHT_BITS-1:0] adj_wdata;
	logic adj_re;
	logic [WEIGHT_BITS-1:0] adj_rdata;

	logic dist_we;
	logic [VW-1:0] dist_waddr;
	logic [DIST_W-1:0] dist_wdata;
	logic dist_re;
	logic [VW-1:0] dist_raddr;
	logic [DIST_W-1:0] dist_rdata;

	dsp_relax_ctl_t relax_ctl;
	logic relax_we;
	logic [DIST_W-1:0] relax_wd;
	logic [DIST_W-1:0] best_d;
	logic [VW-1:0] best_idx;

	always_comb begin
		from_ext = DIST_W'(req.from_vertex);
		to_ext = DIST_W'(req.to_vertex);
		wb_ext = DIST_W'(req.edge_weight);
		from_ok = from_ext < DIST_W'(VERTICES);
		to_ok = to_ext < DIST_W'(VERTICES);
		req_acc = req_valid && (state_q == S_IDLE);
		edge_we = req_acc && (req.mode == MODE_EDGE) && from_ok && to_ok;
		run_go = req_acc && (req.mode == MODE_RUN);
		start_idx = from_ok ? from_ext[VW-1:0] : LAST_V;
		final_d = tgt_ok_q ? dist_rdata : DIST_INF;

		adj_we = (state_q == S_CLEAR) || edge_we;
		adj_waddr = (state_q == S_CLEAR) ? clr_addr_q : {from_ext[VW-1:0], to_ext[VW-1:0]};
		adj_wdata = (state_q == S_CLEAR) ? '0 : wb_ext[WEIGHT_BITS-1:0];
		adj_re = (state_q == S_ISSUE);

		dist_we = run_go ? from_ok : relax_we;
		dist_waddr = run_go ? start_idx : v_s1;
		dist_wdata = run_go ? '0 : relax_wd;
		dist_re = (state_q == S_ISSUE) || (state_q == S_FETCH);
		dist_raddr = (state_q == S_FETCH) ? tgt_idx_q : v_q;

		relax_ctl.valid = issue_s1;
		relax_ctl.visited = vis_s1;
		relax_ctl.clr_best = run_go || (state_q == S_ROUND);
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_vld_q;
	assign rsp = out_q;

	dsp_adj_mem #(
		.AW(AW),
		.DW(WEIGHT_BITS)
	) u_adj (
		.clk(clk),
		.we(adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.re(adj_re),
		.raddr({u_q, v_q}),
		.rdata(adj_rdata)
	);

	dsp_dist_mem #(
		.DEPTH(VERTICES),
		.IW(VW)
	) u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.clr(run_go),
		.we(dist_we),
		.waddr(dist_waddr),
		.wdata(dist_wdata),
		.re(dist_re),
		.raddr(dist_raddr),
		.rdata(dist_rdata)
	);

	dsp_relax_unit #(
		.WEIGHT_BITS(WEIGHT_BITS),
		.IW(VW)
	) u_relax (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(relax_ctl),
		.du(du_q),
		.w(adj_rdata),
		.d(dist_rdata),
		.v(v_s1),
		.wr_en(relax_we),
		.wr_data(relax_wd),
		.best_d(best_d),
		.best_idx(best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_addr_q <= '0;
			drain_q <= 1'b0;
			u_q <= '0;
			du_q <= DIST_INF;
			round_q <= '0;
			v_q <= '0;
			visited_q <= '0;
			tgt_q <= '0;
			tgt_idx_q <= '0;
			tgt_ok_q <= 1'b0;
			issue_s1 <= 1'b0;
			vis_s1 <= 1'b0;
			v_s1 <= '0;
			out_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			issue_s1 <= (state_q == S_ISSUE);
			vis_s1 <= visited_q[v_q];
			v_s1 <= v_q;
			if (out_vld_q && !rsp_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (run_go) begin
						u_q <= start_idx;
						du_q <= from_ok ? '0 : DIST_INF;
						visited_q <= '0;
						visited_q[start_idx] <= 1'b1;
						round_q <= '0;
						v_q <= '0;
						tgt_q <= req.to_vertex;
						tgt_idx_q <= to_ext[VW-1:0];
						tgt_ok_q <= to_ok;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					v_q <= v_q + 1'b1;
					if (v_q == LAST_V) begin
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (round_q == LAST_ROUND) begin
						state_q <= S_FETCH;
					end else begin
						u_q <= best_idx;
						du_q <= best_d;
						visited_q[best_idx] <= 1'b1;
						round_q <= round_q + 1'b1;
						v_q <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_FETCH: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!out_vld_q || !rsp_stall) begin
						out_q.target_distance <= final_d;
						out_q.reachable <= (final_d != DIST_INF);
						out_q.target_echo <= tgt_q;
						out_vld_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

/* sv/dsp_adj_mem.sv */
// Adjacency weight memory with one write port and one registered read port.
`timescale 1ns / 1ps
module dsp_adj_mem #(
	parameter int AW = 8,
	parameter int DW = 16
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [1 << AW];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;
endmodule

/* sv/dsp_dist_mem.sv */
// Distance memory with written flags so that unwritten entries read as infinity.
`timescale 1ns / 1ps
module dsp_dist_mem #(
	parameter int DEPTH = 16,
	parameter int IW = 4
) (
	input logic clk,
	input logic arst_n,
	input logic clr,
	input logic we,
	input logic [IW-1:0] waddr,
	input logic [dsp_pkg::DIST_W-1:0] wdata,
	input logic re,
	input logic [IW-1:0] raddr,
	output logic [dsp_pkg::DIST_W-1:0] rdata
);
	import dsp_pkg::*;

	logic [DIST_W-1:0] mem_q [DEPTH];
	logic [DIST_W-1:0] rd_q;
	logic [DEPTH-1:0] written_q;
	logic rd_ok_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (clr) begin
				written_q <= '0;
			end
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_ok_q <= written_q[raddr];
			end
		end
	end

	assign rdata = rd_ok_q ? rd_q : DIST_INF;
endmodule

/* sv/dsp_relax_unit.sv */
// Shared relaxation unit: saturating add and compare, then a registered minimum pick.
`timescale 1ns / 1ps
module dsp_relax_unit #(
	parameter int WEIGHT_BITS = 16,
	parameter int IW = 4
) (
	input logic clk,
	input logic arst_n,
	input dsp_pkg::dsp_relax_ctl_t ctl,
	input logic [dsp_pkg::DIST_W-1:0] du,
	input logic [WEIGHT_BITS-1:0] w,
	input logic [dsp_pkg::DIST_W-1:0] d,
	input logic [IW-1:0] v,
	output logic wr_en,
	output logic [dsp_pkg::DIST_W-1:0] wr_data,
	output logic [dsp_pkg::DIST_W-1:0] best_d,
	output logic [IW-1:0] best_idx
);
	import dsp_pkg::*;

	logic [DIST_W:0] sum;
	logic [DIST_W-1:0] cand;
	logic [DIST_W-1:0] newd;
	logic relax;
	logic pick_vld_s2;
	logic [DIST_W-1:0] pick_d_s2;
	logic [IW-1:0] pick_v_s2;
	logic [DIST_W-1:0] best_q;
	logic [IW-1:0] best_idx_q;

	always_comb begin
		sum = {1'b0, du} + (DIST_W + 1)'(w);
		cand = (sum > {1'b0, DIST_CAP}) ? DIST_CAP : sum[DIST_W-1:0];
		relax = ctl.valid && !ctl.visited && (w != '0) && (du != DIST_INF) && (cand < d);
		newd = relax ? cand : d;
	end

	assign wr_en = relax;
	assign wr_data = cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_vld_s2 <= 1'b0;
			best_q <= DIST_INF;
			best_idx_q <= '0;
		end else begin
			pick_vld_s2 <= ctl.valid && !ctl.visited;
			if (ctl.clr_best) begin
				best_q <= DIST_INF;
				best_idx_q <= '0;
			end else if (pick_vld_s2 && (pick_d_s2 <= best_q)) begin
				best_q <= pick_d_s2;
				best_idx_q <= pick_v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		pick_d_s2 <= newd;
		pick_v_s2 <= v;
	end

	assign best_d = best_q;
	assign best_idx = best_idx_q;
endmodule

/* sv/dsp_checker.sv */
// Port-level checks for the shortest path engine and their binding to the top level.
`timescale 1ns / 1ps
module dsp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input dsp_pkg::dsp_req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input dsp_pkg::dsp_rsp_t rsp
);
	import dsp_pkg::*;

	a_reach_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.reachable == (rsp.target_distance != DIST_INF)))
		else $error("The reachable flag disagrees with the reported distance.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("A stalled result beat changed or was dropped.");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.mode == MODE_RUN) |=> req_stall)
		else $error("The engine took a new beat right after starting a run.");

	a_edge_quick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.mode == MODE_EDGE) |=> !req_stall)
		else $error("An edge write did not complete in one cycle.");

	a_rsp_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("A result beat appeared while the engine was idle.");
endmodule

bind dijkstra_shortest_path dsp_checker u_dsp_checker (.*);

/* sim/dsp_path_checker.sv */
// Checker that predicts shortest path results from observed request beats and compares them.
`timescale 1ns / 1ps
module dsp_path_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input dsp_pkg::dsp_req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input dsp_pkg::dsp_rsp_t rsp,
	output int mismatches,
	output int pending,
	output int edge_beats,
	output int run_beats
);
	import dsp_pkg::*;

	localparam int NV = DEF_VERTICES;
	localparam int WB = DEF_WEIGHT_BITS;

	logic [WB-1:0] adjacency [NV][NV];
	dsp_rsp_t pending_distances [$];

	function automatic dsp_rsp_t shortest_to(input logic [VTX_W-1:0] src,
			input logic [VTX_W-1:0] dst);
		logic [DIST_W-1:0] path_d [NV];
		logic seen [NV];
		logic [DIST_W-1:0] best;
		logic [DIST_W:0] sum;
		int u;
		dsp_rsp_t res;
		for (int v = 0; v < NV; v++) begin
			path_d[v] = DIST_INF;
			seen[v] = 1'b0;
		end
		if (int'(src) < NV)
			path_d[src] = '0;
		for (int r = 0; r < NV - 1; r++) begin
			best = DIST_INF;
			u = 0;
			for (int v = 0; v < NV; v++) begin
				if (!seen[v] && path_d[v] <= best) begin
					best = path_d[v];
					u = v;
				end
			end
			seen[u] = 1'b1;
			if (path_d[u] != DIST_INF) begin
				for (int v = 0; v < NV; v++) begin
					if (!seen[v] && adjacency[u][v] != '0) begin
						sum = (DIST_W + 1)'(path_d[u]) + (DIST_W + 1)'(adjacency[u][v]);
						if (sum > (DIST_W + 1)'(DIST_CAP))
							sum = (DIST_W + 1)'(DIST_CAP);
						if (sum[DIST_W-1:0] < path_d[v])
							path_d[v] = sum[DIST_W-1:0];
					end
				end
			end
		end
		res.target_distance = (int'(dst) < NV) ? path_d[dst] : DIST_INF;
		res.reachable = (res.target_distance != DIST_INF);
		res.target_echo = dst;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dsp_rsp_t want;
		if (!arst_n) begin
			for (int f = 0; f < NV; f++)
				for (int t = 0; t < NV; t++)
					adjacency[f][t] = '0;
			pending_distances.delete();
			mismatches = 0;
			pending <= 0;
			edge_beats <= 0;
			run_beats <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				if (req.mode == MODE_EDGE) begin
					if (int'(req.from_vertex) < NV && int'(req.to_vertex) < NV)
						adjacency[req.from_vertex][req.to_vertex] = req.edge_weight[WB-1:0];
					edge_beats <= edge_beats + 1;
				end else begin
					pending_distances.push_back(shortest_to(req.from_vertex, req.to_vertex));
					run_beats <= run_beats + 1;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_distances.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result beat with nothing expected: dist %h reach %b tgt %0d",
							$time, rsp.target_distance, rsp.reachable, rsp.target_echo);
					mismatches = mismatches + 1;
				end else begin
					want = pending_distances.pop_front();
					if (rsp.target_distance !== want.target_distance ||
							rsp.reachable !== want.reachable ||
							rsp.target_echo !== want.target_echo) begin
						if (mismatches < 10)
							$display("%0t: expected dist %h reach %b tgt %0d, got dist %h reach %b tgt %0d",
								$time, want.target_distance, want.reachable, want.target_echo,
								rsp.target_distance, rsp.reachable, rsp.target_echo);
						mismatches = mismatches + 1;
					end
				end
			end
			pending <= pending_distances.size();
		end
	end

endmodule

/* sim/tb_dijkstra_shortest_path.sv */
// Testbench top that drives edge and run beats into the shortest path engine and reports the verdict.
`timescale 1ns / 1ps
module tb_dijkstra_shortest_path;
	import dsp_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 3000;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 400;
	localparam int REQ_W = $bits(dsp_req_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	dsp_req_t req = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	dsp_rsp_t rsp;

	int mismatches;
	int pending;
	int edge_beats;
	int run_beats;

	int idle_profile = 0;
	int items_sent = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;

	always #1 clk = ~clk;

	dijkstra_shortest_path u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	dsp_path_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.mismatches(mismatches),
		.pending(pending),
		.edge_beats(edge_beats),
		.run_beats(run_beats)
	);

	function automatic int send_idle_pct();
		case (idle_profile)
			0: return 27;
			1: return 48;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (idle_profile)
			0: return 48;
			1: return 27;
			default: return 0;
		endcase
	endfunction

	function automatic logic [WEIGHT_FIELD_W-1:0] rand_weight();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return WEIGHT_FIELD_W'($urandom_range(1, 4));
		else if (pick < 80)
			return WEIGHT_FIELD_W'($urandom);
		else if (pick < 90)
			return '0;
		else
			return {1'b1, (WEIGHT_FIELD_W - 1)'($urandom)};
	endfunction

	function automatic logic [VTX_W-1:0] focus_vertex(input int base, input int span);
		return VTX_W'(base + $urandom_range(span - 1));
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", LIMIT, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct());
		end
	end

	task automatic send_beat(input dsp_req_t item);
		while ($urandom_range(99) < send_idle_pct()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic put_edge(input logic [VTX_W-1:0] from_v, input logic [VTX_W-1:0] to_v,
			input logic [WEIGHT_FIELD_W-1:0] weight);
		dsp_req_t item;
		item.mode = MODE_EDGE;
		item.from_vertex = from_v;
		item.to_vertex = to_v;
		item.edge_weight = weight;
		send_beat(item);
	endtask

	task automatic put_run(input logic [VTX_W-1:0] start_v, input logic [VTX_W-1:0] target_v);
		dsp_req_t item;
		item.mode = MODE_RUN;
		item.from_vertex = start_v;
		item.to_vertex = target_v;
		item.edge_weight = WEIGHT_FIELD_W'($urandom);
		send_beat(item);
	endtask

	initial begin
		int pick;
		int base;
		int span;
		int count;
		dsp_req_t item;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_run(4'd0, 4'd5);
		put_run(4'd3, 4'd3);
		put_edge(4'd0, 4'd1, 16'hFFFF);
		put_edge(4'd1, 4'd2, 16'hFFFF);
		put_edge(4'd0, 4'd2, 16'd1);
		put_edge(4'd2, 4'd15, 16'd1);
		put_run(4'd0, 4'd15);
		put_edge(4'd0, 4'd2, 16'd0);
		put_run(4'd0, 4'd15);
		put_edge(4'd0, 4'd3, 16'd5);
		put_edge(4'd0, 4'd4, 16'd5);
		put_edge(4'd3, 4'd5, 16'd1);
		put_edge(4'd4, 4'd5, 16'd1);
		put_edge(4'd5, 4'd5, 16'd7);
		put_edge(4'd2, 4'd0, 16'd1);
		put_run(4'd0, 4'd5);
		put_run(4'd15, 4'd0);
		put_run(4'd0, 4'd0);
		put_edge(4'd15, 4'd0, 16'h8000);
		put_run(4'd15, 4'd1);
		put_edge(4'd15, 4'd15, 16'hFFFF);
		put_run(4'd15, 4'd14);
		put_run(4'd1, 4'd15);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
				idle_profile = 2;
				hold_go = 1'b1;
			end else if (items_sent >= RANDOM_ITEMS / 3) begin
				idle_profile = 1;
			end
			pick = $urandom_range(99);
			if (pick < 75) begin
				base = $urandom_range(15);
				span = $urandom_range(2, 16);
				count = $urandom_range(1, 10);
				repeat (count)
					put_edge(focus_vertex(base, span), focus_vertex(base, span), rand_weight());
				if ($urandom_range(99) < 70)
					put_run(focus_vertex(base, span), focus_vertex(base, span));
				else
					put_run(VTX_W'($urandom), VTX_W'($urandom));
			end else if (pick < 85) begin
				base = $urandom_range(15);
				for (int v = 0; v < DEF_VERTICES; v++)
					put_edge(VTX_W'(base), VTX_W'(v), '0);
			end else begin
				item = dsp_req_t'(REQ_W'($urandom));
				send_beat(item);
			end
		end
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d edge writes and %0d path queries over three idle profiles,",
			edge_beats, run_beats);
		$display("with one %0d-cycle result hold-off that backed up the request side.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
sv/dsp_pkg.sv
sv/dsp_adj_mem.sv
sv/dsp_dist_mem.sv
sv/dsp_relax_unit.sv
sv/dijkstra_shortest_path.sv
sv/dsp_checker.sv
sim/dsp_path_checker.sv
sim/tb_dijkstra_shortest_path.sv
